// ----- hdl/aft_pkg.sv -----
// Package for the accent folding tokenizer: payload types, codes and fold tables.
package aft_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } aft_req_type;

   typedef struct packed {
      logic       item_kind;
      logic [6:0] out_char;
      logic       last_of_token;
   } aft_rsp_type;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOS  = 1'b1;

   localparam logic [7:0] NO_FOLD    = 8'h80;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   function automatic logic [7:0] pick(input logic lc, input logic [7:0] up);
      return lc ? (up + CASE_DELTA) : up;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic logic [7:0] fold_pair(input logic [7:0] a, input logic [7:0] b,
                                            input logic lc);
      logic [7:0] r;
      r = NO_FOLD;
      if (a == 8'hC2) begin
         if (b == 8'hAA) r = "a";
         else if (b == 8'hBA || b == 8'hA9 || b == 8'hAE) r = CHAR_SPACE;
      end else if (a == 8'hC3) begin
         if (b >= 8'h80 && b <= 8'h85) r = pick(lc, "A");
         else if (b >= 8'hA0 && b <= 8'hA5) r = "a";
         else if (b >= 8'h88 && b <= 8'h8B) r = pick(lc, "E");
         else if (b >= 8'hA8 && b <= 8'hAB) r = "e";
         else if (b >= 8'h8C && b <= 8'h8F) r = pick(lc, "I");
         else if (b >= 8'hAC && b <= 8'hAF) r = "i";
         else if (b >= 8'h92 && b <= 8'h96) r = pick(lc, "O");
         else if (b >= 8'hB2 && b <= 8'hB6) r = "o";
         else if (b >= 8'h99 && b <= 8'h9C) r = pick(lc, "U");
         else if (b >= 8'hB9 && b <= 8'hBC) r = "u";
         else if (b == 8'h87) r = pick(lc, "C");
         else if (b == 8'hA7) r = "c";
         else if (b == 8'h91) r = pick(lc, "N");
         else if (b == 8'hB1) r = "n";
         else if (b == 8'h9F) r = "s";
         else if (b == 8'h9D) r = pick(lc, "Y");
         else if (b == 8'hBD || b == 8'hBF) r = "y";
      end else if (a == 8'hC5) begin
         if (b == 8'hBD) r = pick(lc, "Z");
         else if (b == 8'hBE) r = "z";
         else if (b == 8'hB8) r = pick(lc, "Y");
      end else if (a == 8'hE2) begin
         if (b == 8'h84) r = CHAR_SPACE;
         else if (b == 8'h80) r = CHAR_QUOTE;
      end
      return r;
   endfunction

   function automatic logic [7:0] fold_single(input logic [7:0] c, input logic lc);
      logic [7:0] r;
      r = NO_FOLD;
      if ((c >= 8'hC0 && c <= 8'hC5)) r = pick(lc, "A");
      else if ((c >= 8'hE1 && c <= 8'hE5) || c == 8'hAA) r = "a";
      else if (c >= 8'hC8 && c <= 8'hCB) r = pick(lc, "E");
      else if (c >= 8'hE8 && c <= 8'hEB) r = "e";
      else if (c >= 8'hCC && c <= 8'hCF) r = pick(lc, "I");
      else if (c >= 8'hEC && c <= 8'hEF) r = "i";
      else if (c >= 8'hD2 && c <= 8'hD6) r = pick(lc, "O");
      else if ((c >= 8'hF2 && c <= 8'hF6) || c == 8'hBA) r = "o";
      else if (c >= 8'hD9 && c <= 8'hDC) r = pick(lc, "U");
      else if (c >= 8'hF9 && c <= 8'hFC) r = "u";
      else if (c == 8'hC7) r = pick(lc, "C");
      else if (c == 8'hA9 || c == 8'hE7) r = "c";
      else if (c == 8'hD1) r = pick(lc, "N");
      else if (c == 8'hF1) r = "n";
      else if (c == 8'hAE) r = "r";
      else if (c == 8'hDF) r = "s";
      else if (c == 8'h8E) r = pick(lc, "Z");
      else if (c == 8'h9E) r = "z";
      else if (c == 8'h9F || c == 8'hDD) r = pick(lc, "Y");
      else if (c == 8'hFD || c == 8'hFF) r = "y";
      return r;
   endfunction

endpackage

// ----- hdl/accent_fold_tokenizer.sv -----
// Accent folding tokenizer: byte stream in, token characters and end markers out.
//
// Usage:
//   req_* carries one byte of text per request, with end_of_string on the
//   final byte. rsp_* returns token characters (item_kind 0) with a
//   last_of_token flag, and one end-of-string marker (item_kind 1) per string.
//   csr_* writes lowercase_enable; csr_ready is always high. Write it only
//   while the block is idle.
// A request is registered in the input register and folded in one pass; its
//   results are written to the result buffer, which drives rsp_*.
// Throughput: one request per cycle while each request yields at most one
//   result and rsp_stall is low; a request yielding more (up to 4) holds the
//   input while the result buffer drains, one entry per cycle unless stalled.
// Reset clears the pending lead byte, the held character and both buffers,
//   and sets lowercase_enable to 1.
// rsp_stall freezes the result buffer; while the input register holds a request
//   that the result buffer cannot yet take, req_stall is high and no request is lost.
module accent_fold_tokenizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aft_pkg::aft_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aft_pkg::aft_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);
   import aft_pkg::*;

   logic        lc_ff;
   logic        in_vld_ff, in_vld_in;
   aft_req_type in_ff;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_lead_ff, pend_lead_in;
   logic        held_valid_ff, held_valid_in;
   logic [6:0]  held_char_ff, held_char_in;
   aft_rsp_type buf_ff [4];
   logic [2:0]  cnt_ff;
   logic [1:0]  rd_ff;

   aft_rsp_type res [4];
   logic [2:0]  n_res;
   logic        pop, can_load, process, accept;

   assign csr_ready = 1'b1;
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = buf_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign can_load  = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && pop);
   assign process   = in_vld_ff && can_load;
   assign req_stall = in_vld_ff && !process;
   assign accept    = req_valid && !req_stall;
   assign in_vld_in = accept || (in_vld_ff && !process);

   // fold and tokenize one byte
   always_comb begin
      logic [7:0] ch [2];
      logic       en [2];
      logic [7:0] b;
      logic [7:0] c;
      logic       eos;
      b   = in_ff.in_byte;
      eos = in_ff.end_of_string;
      c   = 8'd0;
      ch[0] = NO_FOLD;
      ch[1] = NO_FOLD;
      en[0] = 1'b0;
      en[1] = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_lead_in  = pend_lead_ff;
      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      n_res = 3'd0;
      for (int i = 0; i < 4; i++) begin
         res[i] = '0;
      end

      if (pend_valid_ff && b[7]) begin
         ch[0] = fold_pair(pend_lead_ff, b, lc_ff);
         en[0] = 1'b1;
         pend_valid_in = 1'b0;
         pend_lead_in  = 8'd0;
      end else begin
         if (pend_valid_ff) begin
            ch[0] = fold_single(pend_lead_ff, lc_ff);
            en[0] = 1'b1;
            pend_valid_in = 1'b0;
            pend_lead_in  = 8'd0;
         end
         if (b[7]) begin
            if (eos) begin
               ch[1] = fold_single(b, lc_ff);
               en[1] = 1'b1;
            end else begin
               pend_lead_in  = b;
               pend_valid_in = 1'b1;
            end
         end else begin
            ch[1] = (lc_ff && b >= "A" && b <= "Z") ? (b + CASE_DELTA) : b;
            en[1] = 1'b1;
         end
      end

      for (int i = 0; i < 2; i++) begin
         if (en[i] && !ch[i][7]) begin
            c = is_punct(ch[i]) ? CHAR_SPACE : ch[i];
            if (held_valid_in) begin
               res[n_res[1:0]] = '{item_kind: KIND_CHAR, out_char: held_char_in,
                                   last_of_token: (c == CHAR_SPACE)};
               n_res = n_res + 3'd1;
            end
            if (c == CHAR_SPACE) begin
               held_valid_in = 1'b0;
               held_char_in  = 7'd0;
            end else begin
               held_valid_in = 1'b1;
               held_char_in  = c[6:0];
            end
         end
      end

      if (eos) begin
         if (held_valid_in) begin
            res[n_res[1:0]] = '{item_kind: KIND_CHAR, out_char: held_char_in,
                                last_of_token: 1'b1};
            n_res = n_res + 3'd1;
         end
         held_valid_in = 1'b0;
         held_char_in  = 7'd0;
         res[n_res[1:0]] = '{item_kind: KIND_EOS, out_char: 7'd0, last_of_token: 1'b0};
         n_res = n_res + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff         <= 1'b1;
         in_vld_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         pend_lead_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         held_char_ff  <= 7'd0;
         cnt_ff        <= 3'd0;
         rd_ff         <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            lc_ff <= csr_data;
         end
         in_vld_ff <= in_vld_in;
         if (process) begin
            pend_valid_ff <= pend_valid_in;
            pend_lead_ff  <= pend_lead_in;
            held_valid_ff <= held_valid_in;
            held_char_ff  <= held_char_in;
            cnt_ff        <= n_res;
            rd_ff         <= 2'd0;
         end else if (pop) begin
            cnt_ff <= cnt_ff - 3'd1;
            rd_ff  <= rd_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (process) begin
         for (int i = 0; i < 4; i++) begin
            buf_ff[i] <= res[i];
         end
      end
   end

endmodule
